// ===== src/srle_pkg.sv =====
// Shared types, constants and widths for the sector RLE byte decoder.
package srle_pkg;

    localparam int SECTOR_BYTES_DEF = 256;
    localparam int HEADER_BYTES_DEF = 3;

    localparam int BW_W      = 17;   // bytes written counter / buffer size
    localparam int MAX_RES   = 3;    // records one byte can produce
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 1'd1;

    localparam logic [7:0] NEG_COLUMNS_RST = 8'd1;
    localparam logic [7:0] ROW_COUNT_RST   = 8'd192;
    localparam logic [7:0] NEG_COLUMNS_WIDE = 8'h01;  // also means 256 columns
    localparam logic [8:0] MAX_COLUMNS      = 9'd256;

    // Stream codes
    localparam logic [7:0] BYTE_ESC  = 8'hFF;
    localparam logic [7:0] BYTE_EOF  = 8'h1A;
    localparam logic [7:0] BYTE_SKIP = 8'hF3;
    localparam logic [7:0] BYTE_ROW  = 8'h88;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] length;
        logic       done;
    } run_rec_t;

    typedef struct packed {
        run_rec_t [MAX_RES-1:0] rec;
        logic [1:0]             count;
    } res_bundle_t;

    typedef struct packed {
        logic [7:0]      prev_lit;
        logic            prev_valid;
        logic            expect_count;
        logic            skip_next;
        logic [BW_W-1:0] written;
        logic            finished;
    } dec_state_t;

    typedef struct packed {
        dec_state_t st;
        logic       emit;
        run_rec_t   rec;
    } dec_out_t;

endpackage

// ===== src/srle_byte_if.sv =====
// Input channel: compressed body bytes.
interface srle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== src/srle_run_if.sv =====
// Output channel: decoded run records.
interface srle_run_if;
    logic       valid;
    logic       ready;
    logic [7:0] run_value;
    logic [7:0] run_length;
    logic       done_res;

    modport source (output valid, output run_value, output run_length, output done_res,
                    input ready);
    modport sink   (input valid, input run_value, input run_length, input done_res,
                    output ready);
endinterface

// ===== src/srle_core.sv =====
// Decode state and the per-byte decision logic with one byte of lookahead.
module srle_core
    import srle_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    input  logic [BW_W-1:0] buf_total,
    output res_bundle_t     res
);

    localparam int OFF_W = $clog2(SECTOR_BYTES);
    localparam logic [OFF_W-1:0] OFF_RST  = OFF_W'(HEADER_BYTES % SECTOR_BYTES);
    localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(SECTOR_BYTES - 1);

    dec_state_t       state_reg, state_next;
    logic [7:0]       held_reg, held_next;
    logic             held_valid_reg, held_valid_next;
    logic [OFF_W-1:0] off_reg, off_next;

    function automatic dec_out_t decide(dec_state_t s, logic [7:0] b, logic sec_start,
                                        logic has_la, logic [7:0] la,
                                        logic [BW_W-1:0] total);
        dec_out_t        o;
        logic [BW_W-1:0] room;
        logic [7:0]      len;
        logic [7:0]      val;
        logic            run;
        o      = '0;
        o.st   = s;
        run    = 1'b0;
        len    = '0;
        val    = '0;
        room   = '0;
        if (!s.finished)
        begin
            if (s.skip_next)
            begin
                o.st.skip_next = 1'b0;
            end
            else if (s.written >= total)
            begin
                o.st.finished = 1'b1;
                o.emit        = 1'b1;
                o.rec.done    = 1'b1;
            end
            else
            begin
                if (sec_start)
                begin
                    o.st.expect_count = 1'b0;
                    o.st.prev_valid   = 1'b0;
                end
                if (has_la && b == BYTE_ESC && la == BYTE_EOF)
                begin
                    o.st.finished = 1'b1;
                    o.emit        = 1'b1;
                    o.rec.done    = 1'b1;
                end
                else if (has_la && b == BYTE_SKIP && la == BYTE_ESC)
                begin
                    o.st.skip_next = 1'b1;
                end
                else if (o.st.expect_count)
                begin
                    o.st.expect_count = 1'b0;
                    o.st.prev_valid   = 1'b0;
                    if (b > 8'd2)
                    begin
                        run = 1'b1;
                        val = s.prev_lit;
                        len = b - 8'd2;
                    end
                end
                else if (b == BYTE_ROW)
                begin
                    o.st.prev_valid = 1'b0;
                end
                else
                begin
                    if (o.st.prev_valid && b == s.prev_lit)
                    begin
                        o.st.expect_count = 1'b1;
                    end
                    else
                    begin
                        o.st.prev_lit   = b;
                        o.st.prev_valid = 1'b1;
                    end
                    run = 1'b1;
                    val = b;
                    len = 8'd1;
                end
                if (run)
                begin
                    // clip the run to what is left of the buffer
                    room = total - s.written;
                    if ({{(BW_W-8){1'b0}}, len} > room)
                        len = room[7:0];
                    o.st.written = s.written + {{(BW_W-8){1'b0}}, len};
                    if (o.st.written >= total)
                        o.st.finished = 1'b1;
                    o.emit       = 1'b1;
                    o.rec.value  = val;
                    o.rec.length = len;
                    o.rec.done   = o.st.finished;
                end
            end
        end
        return o;
    endfunction

    always_comb
    begin
        dec_out_t                d_held;
        dec_out_t                d_last;
        dec_state_t              s1;
        dec_state_t              s2;
        logic [OFF_W-1:0]        off_h;
        run_rec_t [MAX_RES-1:0]  cand;
        logic [MAX_RES-1:0]      cand_v;
        logic [1:0]              n;

        off_h   = (off_reg == '0) ? OFF_LAST : off_reg - 1'b1;
        d_held  = '0;
        d_last  = '0;
        cand    = '0;
        cand_v  = '0;
        s1      = state_reg;
        s2      = state_reg;

        state_next      = state_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        off_next        = off_reg;

        if (!state_reg.finished)
        begin
            off_next = (off_reg == OFF_LAST) ? '0 : off_reg + 1'b1;
            if (held_valid_reg)
            begin
                d_held    = decide(state_reg, held_reg, off_h == '0, 1'b1, data_byte,
                                   buf_total);
                s1        = d_held.st;
                cand[0]   = d_held.rec;
                cand_v[0] = d_held.emit;
            end
            s2 = s1;
            held_valid_next = 1'b0;
            if (last_byte)
            begin
                d_last    = decide(s1, data_byte, off_reg == '0, 1'b0, 8'd0, buf_total);
                s2        = d_last.st;
                cand[1]   = d_last.rec;
                cand_v[1] = d_last.emit;
                if (!s2.finished)
                begin
                    s2.finished = 1'b1;
                    cand_v[2]   = 1'b1;
                    cand[2]     = '{value: 8'd0, length: 8'd0, done: 1'b1};
                end
            end
            else if (!s1.finished)
            begin
                held_next       = data_byte;
                held_valid_next = 1'b1;
            end
            state_next = s2;
        end

        // pack emitted records in order
        res = '0;
        n   = 2'd0;
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (cand_v[i])
            begin
                res.rec[n] = cand[i];
                n          = n + 2'd1;
            end
        end
        res.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '0;
            held_valid_reg <= 1'b0;
            off_reg        <= OFF_RST;
        end
        else if (fire)
        begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
            off_reg        <= off_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            held_reg <= held_next;
    end

endmodule

// ===== src/srle_obuf.sv =====
// Three-slot result buffer: loads all records of one byte, drains one per cycle while ready is high.
module srle_obuf
    import srle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  res_bundle_t res,
    input  logic        load,
    output logic        can_load,
    output logic        valid,
    input  logic        ready,
    output run_rec_t    rec
);

    run_rec_t [MAX_RES-1:0] slot_reg;
    logic [1:0]             count_reg, count_next;
    logic [1:0]             rd_reg, rd_next;
    logic                   pop;

    assign valid    = (count_reg != 2'd0);
    assign pop      = valid && ready;
    assign can_load = (count_reg == 2'd0) || (count_reg == 2'd1 && pop);
    assign rec      = slot_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        rd_next    = rd_reg;
        if (load)
        begin
            count_next = res.count;
            rd_next    = 2'd0;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            rd_next    = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= res.rec;
    end

endmodule

// ===== src/sector_rle_byte_decoder.sv =====
// Sector RLE byte decoder: compressed body bytes in, (value, length) run records out.
// Takes one body byte per transaction on byte_ch and emits run records on run_ch. A byte is
// decided when the following byte arrives (one byte of lookahead). Its record reaches run_ch
// through the input register and the result buffer: the next byte sits in the input register
// while the decode logic loads the result buffer. A byte that yields at most one record keeps
// the rate at one byte per cycle while run_ch.ready stays high. The byte flagged last_byte can
// yield up to three records (the held byte, the last byte itself and the closing zero-length
// record); the three-slot result buffer then drains one record per cycle while run_ch.ready
// is high, and input stalls until the buffer is down to its last record. The end marker
// FF 1A, a full buffer or the last byte produce the record with done_res set; after it every
// byte is taken and dropped until reset. Match state is cleared at each SECTOR_BYTES boundary
// of the file offset, which starts at HEADER_BYTES. The buffer size (rows times columns) is
// registered from the configuration registers; write them only while no transaction is in
// flight. No clearing pass is needed after reset.
module sector_rle_byte_decoder
    import srle_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    srle_byte_if.sink            byte_ch,
    srle_run_if.source           run_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // configuration registers
    logic [7:0]      neg_columns_reg;
    logic [7:0]      row_count_reg;
    logic [8:0]      columns;
    logic [BW_W-1:0] total_reg;

    // input register stage
    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       in_take;

    // decode / result buffer
    res_bundle_t res;
    logic        can_load;
    logic        fire;
    run_rec_t    out_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_columns_reg <= NEG_COLUMNS_RST;
            row_count_reg   <= ROW_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NEG_COLUMNS: neg_columns_reg <= cfg_data;
                CFG_ROW_COUNT:   row_count_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Header stores ~(columns-1); codes 0 and 1 both mean 256 columns.
    assign columns = (neg_columns_reg == NEG_COLUMNS_WIDE) ? MAX_COLUMNS
                                                           : {1'b0, ~neg_columns_reg} + 9'd1;

    // Buffer size, registered so the multiply stays off the decode path.
    always_ff @(posedge clk)
    begin
        total_reg <= {{(BW_W-8){1'b0}}, row_count_reg} * {{(BW_W-9){1'b0}}, columns};
    end

    // Input stage: refilled in the same cycle the decoder consumes it.
    assign fire           = in_valid_reg && can_load;
    assign byte_ch.ready  = !in_valid_reg || fire;
    assign in_take        = byte_ch.valid && byte_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= byte_ch.data_byte;
            in_last_reg <= byte_ch.last_byte;
        end
    end

    srle_core #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .buf_total (total_reg),
        .res       (res)
    );

    srle_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .load     (fire),
        .can_load (can_load),
        .valid    (run_ch.valid),
        .ready    (run_ch.ready),
        .rec      (out_rec)
    );

    assign run_ch.run_value  = out_rec.value;
    assign run_ch.run_length = out_rec.length;
    assign run_ch.done_res   = out_rec.done;

endmodule
